@@ rtl/core/rrs_pkg.sv @@
// Shared constants, types and helpers of the reservoir row sampler.
package rrs_pkg;

   localparam int MAX_SLOTS   = 64;
   localparam int MAX_COLUMNS = 16;
   localparam int COUNT_BITS  = 32;

   localparam int KIND_W    = 1;
   localparam int VALUE_W   = 64;
   localparam int RND_W     = 32;
   localparam int RSLOT_W   = 6;
   localparam int RCOL_W    = 4;
   localparam int TSLOT_W   = 6;
   localparam int INDEX_W   = 32;
   localparam int SEEN_W    = 32;
   localparam int NS_W      = 7;
   localparam int RL_W      = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ADDR_W = SLOT_W + COL_W;
   localparam int DIV_W  = (COUNT_BITS > RND_W) ? COUNT_BITS : RND_W;
   localparam int STEP_W = $clog2(DIV_W + 1);

   localparam logic [NS_W-1:0] NUM_SAMPLES_RESET = NS_W'(64);
   localparam logic [RL_W-1:0] ROW_LENGTH_RESET  = RL_W'(16);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_SAMPLES = 1'b0,
      CSR_ROW_LENGTH  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_READ = 2'd1,
      OP_SKIP = 2'd2
   } op_type;

   localparam logic [KIND_W-1:0] KIND_PUSH = 1'b0;

   typedef struct packed {
      op_type             op;
      logic [VALUE_W-1:0] element_value;
      logic [RND_W-1:0]   random_word;
      logic [RSLOT_W-1:0] read_slot;
      logic [RCOL_W-1:0]  read_column;
   } item_type;

   typedef struct packed {
      logic               row_kept;
      logic [TSLOT_W-1:0] target_slot;
      logic [VALUE_W-1:0] read_value;
      logic [INDEX_W-1:0] read_row_index;
      logic [SEEN_W-1:0]  rows_seen;
   } result_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } mod_req_type;

   function automatic logic [INDEX_W-1:0] sat32(input logic [COUNT_BITS-1:0] v);
      logic [INDEX_W-1:0] r;
      r = INDEX_W'(v);
      if (COUNT_BITS > INDEX_W && v > COUNT_BITS'({INDEX_W{1'b1}})) begin
         r = '1;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/reservoir_row_sampler_unit.sv @@
// Top level of the reservoir row sampler: control registers, front end and back end.
//
//   channel  direction  handshake                transfer when
//   req_*    in         req_push / req_full      req_push && !req_full
//   rsp_*    out        rsp_pop / rsp_empty      rsp_pop && !rsp_empty
//   csr_*    in         csr_write_enable         csr_write_enable
//
// One item is worked at a time. A read goes through a registered memory read.
// A non-first row element and a disabled push are finished straight from idle;
// so is a row's first element while the reservoir fills, otherwise it waits for
// the bit-serial remainder. A 2-entry request queue and a 2-entry result queue
// decouple both sides. Reset is synchronous; memories are not cleared.
module reservoir_row_sampler_unit
   import rrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [VALUE_W-1:0]   req_element_value,
   input  logic [RND_W-1:0]     req_random_word,
   input  logic [RSLOT_W-1:0]   req_read_slot,
   input  logic [RCOL_W-1:0]    req_read_column,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic                 rsp_row_kept,
   output logic [TSLOT_W-1:0]   rsp_target_slot,
   output logic [VALUE_W-1:0]   rsp_read_value,
   output logic [INDEX_W-1:0]   rsp_read_row_index,
   output logic [SEEN_W-1:0]    rsp_rows_seen,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_write_data
);

   logic [NS_W-1:0] num_samples_ff, num_samples_in;
   logic [RL_W-1:0] row_length_ff, row_length_in;
   logic            item_valid;
   item_type        item;
   logic            item_pop;
   result_type      result;

   always_comb begin
      num_samples_in = num_samples_ff;
      row_length_in  = row_length_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_SAMPLES: num_samples_in = NS_W'(csr_write_data);
            CSR_ROW_LENGTH:  row_length_in  = RL_W'(csr_write_data);
            default: begin
               num_samples_in = num_samples_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_samples_ff <= NUM_SAMPLES_RESET;
         row_length_ff  <= ROW_LENGTH_RESET;
      end else begin
         num_samples_ff <= num_samples_in;
         row_length_ff  <= row_length_in;
      end
   end

   rrs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_kind          (req_kind),
      .req_element_value (req_element_value),
      .req_random_word   (req_random_word),
      .req_read_slot     (req_read_slot),
      .req_read_column   (req_read_column),
      .num_samples       (num_samples_ff),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop)
   );

   rrs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .num_samples (num_samples_ff),
      .row_length  (row_length_ff),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_result  (result)
   );

   assign rsp_row_kept       = result.row_kept;
   assign rsp_target_slot    = result.target_slot;
   assign rsp_read_value     = result.read_value;
   assign rsp_read_row_index = result.read_row_index;
   assign rsp_rows_seen      = result.rows_seen;

endmodule

@@ rtl/core/rrs_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
module rrs_front
   import rrs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [VALUE_W-1:0]  req_element_value,
   input  logic [RND_W-1:0]    req_random_word,
   input  logic [RSLOT_W-1:0]  req_read_slot,
   input  logic [RCOL_W-1:0]   req_read_column,
   input  logic [NS_W-1:0]     num_samples,
   output logic                item_valid,
   output item_type            item,
   input  logic                item_pop
);

   localparam int DEPTH = 2;

   item_type   queue_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       transfer;
   logic       do_pop;
   item_type   new_item;

   assign req_full   = (count_ff == 2'(DEPTH));
   assign item_valid = (count_ff != 2'd0);
   assign item       = queue_ff[rd_ptr_ff];
   assign transfer   = req_push && !req_full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      new_item.element_value = req_element_value;
      new_item.random_word   = req_random_word;
      new_item.read_slot     = req_read_slot;
      new_item.read_column   = req_read_column;
      if (req_kind != KIND_PUSH) begin
         new_item.op = OP_READ;
      end else if (num_samples == '0) begin
         new_item.op = OP_SKIP;
      end else begin
         new_item.op = OP_PUSH;
      end
      wr_ptr_in = transfer ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(transfer) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (transfer) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/rrs_mod_unit.sv @@
// Iterative restoring remainder unit, one quotient bit per cycle.
module rrs_mod_unit
   import rrs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mod_req_type      mod_req,
   output logic             mod_done,
   output logic [DIV_W-1:0] mod_rem
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_W:0]    shifted;
   logic [DIV_W:0]    diff;

   assign mod_done = done_ff;
   assign mod_rem  = rem_ff;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (mod_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIV_W);
         rem_in  = '0;
         dvd_in  = mod_req.dividend;
         dvs_in  = mod_req.divisor;
      end else if (busy_ff) begin
         rem_in  = (shifted >= {1'b0, dvs_ff}) ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         dvd_in  = {dvd_ff[DIV_W-2:0], 1'b0};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/core/rrs_back.sv @@
// Back end: row sequencing, reservoir memories and the result queue.
module rrs_back
   import rrs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [NS_W-1:0] num_samples,
   input  logic [RL_W-1:0] row_length,
   input  logic            item_valid,
   input  item_type        item,
   output logic            item_pop,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output result_type      rsp_result
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_READ = 3'b100
   } state_type;

   localparam int OUT_DEPTH = 2;

   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  counter_ff, counter_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic                   cur_kept_ff, cur_kept_in;
   logic [SLOT_W-1:0]      cur_slot_ff, cur_slot_in;

   logic [VALUE_W-1:0]     sample_store [1 << ADDR_W];
   logic [INDEX_W-1:0]     slot_row_index [1 << SLOT_W];
   logic [VALUE_W-1:0]     store_rdata_ff;
   logic [INDEX_W-1:0]     index_rdata_ff;
   logic                   in_range_ff, in_range_in;

   result_type             out_q_ff [OUT_DEPTH];
   logic                   out_wr_ff, out_rd_ff;
   logic [1:0]             out_cnt_ff, out_cnt_in;
   logic                   out_full;
   logic                   enq;
   logic                   deq;
   result_type             enq_data;

   logic [NS_W-1:0]        ns_eff;
   logic [RL_W-1:0]        rl_eff;
   logic                   first;
   logic [COUNT_BITS-1:0]  n_cnt;
   logic                   r_small;
   logic                   rem_small;
   logic                   commit;
   logic                   first_c;
   logic                   kept_c;
   logic [SLOT_W-1:0]      slot_c;
   logic [COL_W-1:0]       col_c;
   logic [31:0]            col_next;
   logic [ADDR_W-1:0]      read_addr;
   logic                   mod_done;
   logic [DIV_W-1:0]       mod_rem;
   mod_req_type            mod_req;

   rrs_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .mod_req  (mod_req),
      .mod_done (mod_done),
      .mod_rem  (mod_rem)
   );

   assign out_full   = (out_cnt_ff == 2'(OUT_DEPTH));
   assign rsp_empty  = (out_cnt_ff == 2'd0);
   assign rsp_result = out_q_ff[out_rd_ff];
   assign deq        = rsp_pop && !rsp_empty;
   assign read_addr  = {SLOT_W'(item.read_slot), COL_W'(item.read_column)};

   always_comb begin
      ns_eff = (32'(num_samples) > 32'(MAX_SLOTS)) ? NS_W'(MAX_SLOTS) : num_samples;
      if (row_length == '0) begin
         rl_eff = RL_W'(1);
      end else if (32'(row_length) > 32'(MAX_COLUMNS)) begin
         rl_eff = RL_W'(MAX_COLUMNS);
      end else begin
         rl_eff = row_length;
      end
      first     = (col_ff == '0) || (32'(col_ff) >= 32'(rl_eff));
      n_cnt     = (counter_ff == '1) ? counter_ff : counter_ff + COUNT_BITS'(1);
      r_small   = counter_ff < COUNT_BITS'(ns_eff);
      rem_small = mod_rem < DIV_W'(ns_eff);

      state_in         = state_ff;
      counter_in       = counter_ff;
      col_in           = col_ff;
      cur_kept_in      = cur_kept_ff;
      cur_slot_in      = cur_slot_ff;
      in_range_in      = in_range_ff;
      item_pop         = 1'b0;
      enq              = 1'b0;
      enq_data         = '0;
      enq_data.rows_seen = sat32(counter_ff);
      commit           = 1'b0;
      first_c          = 1'b0;
      kept_c           = 1'b0;
      slot_c           = '0;
      col_c            = '0;
      col_next         = '0;
      mod_req.start    = 1'b0;
      mod_req.dividend = DIV_W'(item.random_word);
      mod_req.divisor  = DIV_W'(n_cnt);

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid && !out_full) begin
               unique case (item.op)
                  OP_READ: begin
                     item_pop    = 1'b1;
                     in_range_in = (32'(item.read_slot) < 32'(MAX_SLOTS)) &&
                                   (32'(item.read_column) < 32'(MAX_COLUMNS));
                     state_in    = S_READ;
                  end
                  OP_SKIP: begin
                     item_pop = 1'b1;
                     enq      = 1'b1;
                  end
                  OP_PUSH: begin
                     if (first && !r_small) begin
                        mod_req.start = 1'b1;
                        col_in        = '0;
                        state_in      = S_DIV;
                     end else begin
                        commit  = 1'b1;
                        first_c = first;
                        kept_c  = first ? 1'b1 : cur_kept_ff;
                        slot_c  = first ? SLOT_W'(counter_ff) : cur_slot_ff;
                     end
                  end
                  default: begin
                     item_pop = 1'b1;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (mod_done) begin
               commit   = 1'b1;
               first_c  = 1'b1;
               kept_c   = rem_small;
               slot_c   = rem_small ? SLOT_W'(mod_rem) : '0;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            enq = 1'b1;
            if (in_range_ff) begin
               enq_data.read_value     = store_rdata_ff;
               enq_data.read_row_index = index_rdata_ff;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (commit) begin
         item_pop             = 1'b1;
         enq                  = 1'b1;
         col_c                = first_c ? '0 : col_ff;
         col_next             = 32'(col_c) + 32'd1;
         col_in               = (col_next >= 32'(rl_eff)) ? '0 : COL_W'(col_next);
         cur_kept_in          = kept_c;
         cur_slot_in          = slot_c;
         enq_data.row_kept    = kept_c;
         enq_data.target_slot = kept_c ? TSLOT_W'(slot_c) : '0;
         if (first_c) begin
            counter_in         = n_cnt;
            enq_data.rows_seen = sat32(n_cnt);
         end
      end

      out_cnt_in = out_cnt_ff + 2'(enq) - 2'(deq);
   end

   always_ff @(posedge clock) begin
      if (commit && kept_c) begin
         sample_store[{slot_c, col_c}] <= item.element_value;
      end
      store_rdata_ff <= sample_store[read_addr];
   end

   always_ff @(posedge clock) begin
      if (commit && kept_c && first_c) begin
         slot_row_index[slot_c] <= sat32(counter_ff);
      end
      index_rdata_ff <= slot_row_index[SLOT_W'(item.read_slot)];
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         out_q_ff[out_wr_ff] <= enq_data;
      end
      in_range_ff <= in_range_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         counter_ff  <= '0;
         col_ff      <= '0;
         cur_kept_ff <= 1'b0;
         cur_slot_ff <= '0;
         out_wr_ff   <= 1'b0;
         out_rd_ff   <= 1'b0;
         out_cnt_ff  <= 2'd0;
      end else begin
         state_ff    <= state_in;
         counter_ff  <= counter_in;
         col_ff      <= col_in;
         cur_kept_ff <= cur_kept_in;
         cur_slot_ff <= cur_slot_in;
         out_wr_ff   <= enq ? ~out_wr_ff : out_wr_ff;
         out_rd_ff   <= deq ? ~out_rd_ff : out_rd_ff;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   a_kept_slot_in_use: assert property (@(posedge clock) disable iff (reset)
      (commit && kept_c && first_c) |-> (32'(slot_c) < 32'(ns_eff)))
      else $error("new kept row targets a slot beyond num_samples");

   a_room_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !out_full)
      else $error("result queue full while an item is in progress");

   a_out_count: assert property (@(posedge clock) disable iff (reset)
      (out_cnt_ff <= 2'(OUT_DEPTH)) && !(enq && out_full))
      else $error("result queue overflow");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (item_valid && $stable(counter_ff)))
      else $error("row count or head item lost during remainder");

endmodule
